FILE: sv/rhdm_pkg.sv
// rhdm_pkg: widths, register indexes, reset values and the command/config
// structs shared by the rolling hash digit matcher modules.
// No dependencies.
package rhdm_pkg;

  localparam int DIGIT_W     = 4;
  localparam int MAX_PATTERN = 16;
  localparam int RADIX       = 10;
  localparam int MOD_W       = 16;
  localparam int LEN_W       = 5;
  localparam int PAT_W       = 64;
  localparam int POS_W       = 32;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);

  // every reduced operand stays below (2^DIGIT_W) * modulus
  localparam int RED_STEPS   = DIGIT_W;
  localparam int STEP_W      = $clog2(RED_STEPS);
  localparam int RED_W       = MOD_W + RED_STEPS;

  localparam int CMDQ_DEPTH  = 4;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_DIGITS = 2'd2;

  localparam logic [MOD_W-1:0] RST_MODULUS    = 16'd13;
  localparam logic [LEN_W-1:0] RST_PAT_LEN    = 5'd5;
  localparam logic [PAT_W-1:0] RST_PAT_DIGITS = 64'd0;
  // 10^4 mod 13 for the reset registers
  localparam logic [MOD_W-1:0] RST_WEIGHT     = 16'd3;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               clear;
    logic               slide;
    logic [DIGIT_W-1:0] oldest;
    logic               emit;
    logic               found;
    logic [POS_W-1:0]   start;
  } cmd_t;

  typedef struct packed {
    logic [MOD_W-1:0] modulus;
    logic [LEN_W-1:0] len;
    logic             derive;
  } cfg_t;

endpackage

FILE: sv/rhdm_front.sv
// rhdm_front: configuration registers, digit window, fill count and text
// position; turns each accepted digit into a command for the hash back end.
// Depends on rhdm_pkg.
module rhdm_front (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  output logic                            in_full,
  input  logic [rhdm_pkg::DIGIT_W-1:0]    in_digit,
  input  logic                            in_new_text,
  input  logic                            cfg_we,
  input  logic [rhdm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rhdm_pkg::CFG_W-1:0]      cfg_wdata,
  output rhdm_pkg::cfg_t                  cfg_o,
  output logic                            cmd_push,
  output rhdm_pkg::cmd_t                  cmd_o,
  input  logic                            cmd_full
);
  import rhdm_pkg::*;

  logic [MOD_W-1:0]   modulus_r;
  logic [LEN_W-1:0]   len_r;
  logic [PAT_W-1:0]   pat_r;
  logic               derive_r;
  logic [DIGIT_W-1:0] win_r   [MAX_PATTERN];
  logic [DIGIT_W-1:0] win_nxt [MAX_PATTERN];
  logic [LEN_W-1:0]   fill_r;
  logic [POS_W-1:0]   pos_r;

  logic [LEN_W-1:0]     len_eff;
  logic [LEN_W-1:0]     len_m1;
  logic [WIN_IDX_W-1:0] lead_idx;
  logic [LEN_W-1:0]     fill_eff;
  logic [LEN_W-1:0]     fill_nxt;
  logic [POS_W-1:0]     pos_eff;
  logic [POS_W-1:0]     pos_nxt;
  logic                 slide;
  logic                 emit;
  logic                 found;
  logic                 accept;
  logic                 cfg_hit;

  always_comb begin
    if (len_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_eff = LEN_W'(MAX_PATTERN);
    end else begin
      len_eff = len_r;
    end
  end

  assign len_m1   = len_eff - LEN_W'(1);
  assign lead_idx = len_m1[WIN_IDX_W-1:0];
  assign fill_eff = in_new_text ? '0 : fill_r;
  assign pos_eff  = in_new_text ? '0 : pos_r;
  assign slide    = (fill_eff >= len_eff);
  assign fill_nxt = slide ? fill_eff : fill_eff + LEN_W'(1);
  assign emit     = (fill_nxt >= len_eff);
  assign pos_nxt  = (emit && (pos_eff != '1)) ? pos_eff + POS_W'(1) : pos_eff;

  // window entries past the fill count are never read, so no clearing needed
  always_comb begin
    win_nxt[0] = in_digit;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // newest digit sits at entry 0, pattern digit 0 lines up with the oldest
  always_comb begin
    logic [WIN_IDX_W-1:0] pidx;
    found = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = lead_idx - WIN_IDX_W'(j);
      if ((LEN_W'(j) < len_eff) && (win_nxt[j] != pat_r[DIGIT_W*pidx +: DIGIT_W])) begin
        found = 1'b0;
      end
    end
  end

  assign accept  = in_push && !cmd_full;
  assign in_full = cmd_full;
  assign cfg_hit = cfg_we && ((cfg_index == REG_MODULUS) || (cfg_index == REG_PAT_LEN) ||
                              (cfg_index == REG_PAT_DIGITS));

  assign cmd_push     = accept;
  assign cmd_o.digit  = in_digit;
  assign cmd_o.clear  = in_new_text;
  assign cmd_o.slide  = slide;
  assign cmd_o.oldest = win_r[lead_idx];
  assign cmd_o.emit   = emit;
  assign cmd_o.found  = found;
  assign cmd_o.start  = pos_eff;

  assign cfg_o.modulus = modulus_r;
  assign cfg_o.len     = len_eff;
  assign cfg_o.derive  = derive_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= RST_MODULUS;
      len_r     <= RST_PAT_LEN;
      pat_r     <= RST_PAT_DIGITS;
      derive_r  <= 1'b0;
      fill_r    <= '0;
      pos_r     <= '0;
    end else begin
      derive_r <= cfg_hit;
      if (cfg_hit) begin
        case (cfg_index)
          REG_MODULUS:    modulus_r <= cfg_wdata[MOD_W-1:0];
          REG_PAT_LEN:    len_r     <= cfg_wdata[LEN_W-1:0];
          REG_PAT_DIGITS: pat_r     <= cfg_wdata[PAT_W-1:0];
          default:        modulus_r <= modulus_r;
        endcase
        fill_r <= '0;
        pos_r  <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
        pos_r  <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      win_r <= win_nxt;
    end
  end

endmodule

FILE: sv/rhdm_cmdq.sv
// rhdm_cmdq: short command queue between the front end and the hash back end.
// Depends on rhdm_pkg.
module rhdm_cmdq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rhdm_pkg::cmd_t din,
  output logic           full,
  input  logic           pop,
  output rhdm_pkg::cmd_t dout,
  output logic           empty
);
  import rhdm_pkg::*;

  cmd_t                  mem [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r;
  logic [CMDQ_PTR_W:0]   count_r;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count_r == (CMDQ_PTR_W+1)'(CMDQ_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + CMDQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + (CMDQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - (CMDQ_PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule

FILE: sv/rhdm_back.sv
// rhdm_back: rolling hash update and leading-digit weight derivation on one
// shared restoring modulo reducer, plus the result register.
// Depends on rhdm_pkg.
module rhdm_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rhdm_pkg::cfg_t               cfg_i,
  input  logic                         cmd_empty,
  input  rhdm_pkg::cmd_t               cmd_i,
  output logic                         cmd_pop,
  input  logic                         out_pop,
  output logic                         out_empty,
  output logic [rhdm_pkg::MOD_W-1:0]   out_window_hash,
  output logic                         out_found,
  output logic [rhdm_pkg::POS_W-1:0]   out_window_start
);
  import rhdm_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DERIV = 7'b0000010,
    S_DRED  = 7'b0000100,
    S_SUB   = 7'b0001000,
    S_ADJ   = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t            state_r, state_nxt;
  logic [MOD_W-1:0]  hash_r, hash_nxt;
  logic [MOD_W-1:0]  weight_r, weight_nxt;
  logic [RED_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [LEN_W-1:0]  iter_r, iter_nxt;
  cmd_t              cmd_r;
  logic              out_v_r, out_v_nxt;
  logic [MOD_W-1:0]  out_hash_r;
  logic              out_found_r;
  logic [POS_W-1:0]  out_start_r;

  logic [RED_W-1:0]  q_ext;
  logic [STEP_W-1:0] step_sh;
  logic [RED_W-1:0]  q_sh;
  logic [RED_W-1:0]  rem_step;
  logic              red_last;
  logic [MOD_W-1:0]  red_res;
  logic [RED_W-1:0]  t_red;
  logic [MOD_W-1:0]  hash_base;
  logic              load_out;

  // one restoring step per cycle, largest multiple of the modulus first
  assign q_ext    = RED_W'(cfg_i.modulus);
  assign step_sh  = STEP_W'(RED_STEPS-1) - step_r;
  assign q_sh     = q_ext << step_sh;
  assign rem_step = (rem_r >= q_sh) ? rem_r - q_sh : rem_r;
  assign red_last = (step_r == STEP_W'(RED_STEPS-1));
  assign red_res  = (cfg_i.modulus == '0) ? '0 : rem_step[MOD_W-1:0];

  // hash + modulus - sub is below twice the modulus
  assign t_red     = (rem_r >= q_ext) ? rem_r - q_ext : rem_r;
  assign hash_base = cmd_i.clear ? '0 : hash_r;
  assign load_out  = (state_r == S_OUT) && (!out_v_r || out_pop);

  always_comb begin
    state_nxt  = state_r;
    hash_nxt   = hash_r;
    weight_nxt = weight_r;
    rem_nxt    = rem_r;
    step_nxt   = step_r;
    iter_nxt   = iter_r;
    cmd_pop    = 1'b0;
    if (cfg_i.derive) begin
      // weight starts at 1 mod q, so zero for a modulus of zero or one
      weight_nxt = MOD_W'(cfg_i.modulus > MOD_W'(1));
      iter_nxt   = cfg_i.len - LEN_W'(1);
      hash_nxt   = '0;
      step_nxt   = '0;
      state_nxt  = S_DERIV;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (!cmd_empty) begin
            cmd_pop  = 1'b1;
            hash_nxt = hash_base;
            if (cmd_i.slide) begin
              rem_nxt   = RED_W'(cmd_i.oldest) * RED_W'(weight_r);
              state_nxt = S_SUB;
            end else begin
              rem_nxt   = RED_W'(hash_base) * RED_W'(RADIX) + RED_W'(cmd_i.digit);
              state_nxt = S_FIN;
            end
          end
        end
        S_DERIV: begin
          if (iter_r == '0) begin
            state_nxt = S_IDLE;
          end else begin
            rem_nxt   = RED_W'(weight_r) * RED_W'(RADIX);
            state_nxt = S_DRED;
          end
        end
        S_DRED: begin
          rem_nxt  = rem_step;
          step_nxt = step_r + STEP_W'(1);
          if (red_last) begin
            weight_nxt = red_res;
            iter_nxt   = iter_r - LEN_W'(1);
            step_nxt   = '0;
            state_nxt  = S_DERIV;
          end
        end
        S_SUB: begin
          rem_nxt  = rem_step;
          step_nxt = step_r + STEP_W'(1);
          if (red_last) begin
            rem_nxt   = RED_W'(hash_r) + q_ext - RED_W'(red_res);
            step_nxt  = '0;
            state_nxt = S_ADJ;
          end
        end
        S_ADJ: begin
          rem_nxt   = RED_W'(t_red[MOD_W-1:0]) * RED_W'(RADIX) + RED_W'(cmd_r.digit);
          state_nxt = S_FIN;
        end
        S_FIN: begin
          rem_nxt  = rem_step;
          step_nxt = step_r + STEP_W'(1);
          if (red_last) begin
            hash_nxt  = red_res;
            step_nxt  = '0;
            state_nxt = cmd_r.emit ? S_OUT : S_IDLE;
          end
        end
        S_OUT: begin
          if (load_out) begin
            state_nxt = S_IDLE;
          end
        end
        default: begin
          state_nxt = S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (load_out) begin
      out_v_nxt = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hash_r   <= '0;
      weight_r <= RST_WEIGHT;
      step_r   <= '0;
      iter_r   <= '0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      hash_r   <= hash_nxt;
      weight_r <= weight_nxt;
      step_r   <= step_nxt;
      iter_r   <= iter_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    if (cmd_pop) begin
      cmd_r <= cmd_i;
    end
    if (load_out) begin
      out_hash_r  <= hash_r;
      out_found_r <= cmd_r.found;
      out_start_r <= cmd_r.start;
    end
  end

  assign out_empty        = !out_v_r;
  assign out_window_hash  = out_hash_r;
  assign out_found        = out_found_r;
  assign out_window_start = out_start_r;

endmodule

FILE: sv/rolling_hash_digit_matcher.sv
// rolling_hash_digit_matcher: top level of the streaming Rabin-Karp digit matcher.
// Depends on rhdm_pkg, rhdm_front, rhdm_cmdq and rhdm_back.
//
//   channel  | ports                                   | transfer when
//   ---------+-----------------------------------------+-------------------
//   input    | in_digit, in_new_text                   | in_push & !in_full
//   result   | out_window_hash, out_found,             | out_pop & !out_empty
//            | out_window_start                        |
//   config   | cfg_index, cfg_wdata                    | cfg_we
//
// while the window fills a digit goes through pop and 4-step hash reduction, and
// the digit that completes it also through result load; once it slides it goes
// through pop, 4-step subtract reduction, adjust, 4-step hash reduction and
// result load, all on the shared 4-step restoring modulo reducer
// after a register write the weight is rebuilt before queued digits are hashed;
// synchronous reset restores modulus 13, length 5
// the front end keeps taking digits while the 4-deep command queue has room;
// a finished result waits in the output register, and the next one holds the
// back end in its load state until the waiting one is taken
module rolling_hash_digit_matcher (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [rhdm_pkg::DIGIT_W-1:0]   in_digit,
  input  logic                           in_new_text,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [rhdm_pkg::MOD_W-1:0]     out_window_hash,
  output logic                           out_found,
  output logic [rhdm_pkg::POS_W-1:0]     out_window_start,
  input  logic                           cfg_we,
  input  logic [rhdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rhdm_pkg::CFG_W-1:0]     cfg_wdata
);
  import rhdm_pkg::*;

  cfg_t cfg;
  cmd_t cmd_in;
  cmd_t cmd_out;
  logic cmd_push;
  logic cmd_full;
  logic cmd_pop;
  logic cmd_empty;

  rhdm_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_digit    (in_digit),
    .in_new_text (in_new_text),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .cfg_o       (cfg),
    .cmd_push    (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full    (cmd_full)
  );

  rhdm_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty)
  );

  rhdm_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_i            (cfg),
    .cmd_empty        (cmd_empty),
    .cmd_i            (cmd_out),
    .cmd_pop          (cmd_pop),
    .out_pop          (out_pop),
    .out_empty        (out_empty),
    .out_window_hash  (out_window_hash),
    .out_found        (out_found),
    .out_window_start (out_window_start)
  );

endmodule

FILE: sv/rhdm_checker.sv
// rhdm_checker: port-level assertions for rolling_hash_digit_matcher, bound
// to the top level below. Depends on rhdm_pkg.
module rhdm_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_full,
  input logic                       out_pop,
  input logic                       out_empty,
  input logic [rhdm_pkg::MOD_W-1:0] out_window_hash,
  input logic                       out_found,
  input logic [rhdm_pkg::POS_W-1:0] out_window_start
);
  import rhdm_pkg::*;

  // reset empties the result register and the command queue
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("reset did not clear result and input queues");

  // a result can only be loaded out of reset
  a_result_after_reset: assert property (@(posedge clk)
    $fell(out_empty) |-> $past(rst_n))
    else $error("result appeared while in reset");

  // a waiting result holds until it is taken
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_window_hash) &&
                                  $stable(out_found) && $stable(out_window_start)))
    else $error("waiting result changed before transfer");

endmodule

bind rolling_hash_digit_matcher rhdm_checker u_rhdm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_full          (in_full),
  .out_pop          (out_pop),
  .out_empty        (out_empty),
  .out_window_hash  (out_window_hash),
  .out_found        (out_found),
  .out_window_start (out_window_start)
);
